>>> hdl/bol_pkg.sv
// types and codes shared by the bounded ordered list block
// no dependencies; used by bounded_ordered_list and its testbench
`default_nettype none

package bol_pkg;

	typedef enum logic [1:0] {
		KIND_FRONT  = 2'd0,
		KIND_BACK   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_SHOW   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STATUS_DONE      = 3'd0,
		STATUS_FULL      = 3'd1,
		STATUS_EMPTY     = 3'd2,
		STATUS_NOT_FOUND = 3'd3,
		STATUS_SHOWN     = 3'd4
	} status_t;

	localparam int DATA_W = 32;

	typedef struct packed {
		kind_t                    kind;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} resp_t;

endpackage

`default_nettype wire

>>> hdl/bol_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module bol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/bol_addr.sv
// shared circular address unit: maps a position in the list to a ram address
// physical = (head + offset) mod DEPTH, both inputs below DEPTH
`default_nettype none

module bol_addr #(
	parameter int DEPTH = 16
) (
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] head,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] offset,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] phys
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IW:0] WRAP = (IW + 1)'(DEPTH);

	logic [IW:0] sum;

	always_comb begin
		sum = {1'b0, head} + {1'b0, offset};
		if (sum >= WRAP) begin
			sum = sum - WRAP;
		end
		phys = sum[IW-1:0];
	end

endmodule

`default_nettype wire

>>> hdl/bounded_ordered_list.sv
// top level of the bounded ordered list: sequencer, list state and result register
// depends on bol_pkg, bol_addr and bol_ram
`default_nettype none

// Holds up to DEPTH signed 32-bit values in order, front first, in a circular
// buffer in a single-port-read ram. A command is taken when start is high and
// busy is low; each result appears on resp for one cycle with resp_valid high
// and cannot be held off. Insert at front or back gives its result in the
// next cycle. Remove reads and then compares each stored entry from the front
// until a match, then moves each later entry down one place with a read and
// then a write, keeping busy high until its result appears. Show reads each
// entry in turn and gives one result per entry, last set on the final one,
// and no result when the list is empty. Each read and the use of its data sit
// in separate states because of the ram's registered read and the one shared
// address unit. No clearing pass follows reset: the list starts empty.
module bounded_ordered_list #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bol_pkg::cmd_t  cmd,
	output logic           resp_valid,
	output bol_pkg::resp_t resp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [IW-1:0] BACK_ONE = IW'(DEPTH - 1);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SRCH_RD  = 7'b0000010,
		ST_SRCH_CMP = 7'b0000100,
		ST_SHIFT_RD = 7'b0001000,
		ST_SHIFT_WR = 7'b0010000,
		ST_SHOW_RD  = 7'b0100000,
		ST_SHOW_OUT = 7'b1000000
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                count_q;
	logic [IW-1:0]                head_q;
	logic [IW-1:0]                idx_q;
	logic [bol_pkg::DATA_W-1:0]   value_q;
	logic                         resp_valid_q;
	bol_pkg::resp_t               resp_q;
	bol_pkg::resp_t               resp_d;

	logic                         accept;
	logic                         full;
	logic                         hit;
	logic                         at_last;
	logic                         next_last;
	logic [CW-1:0]                last_idx;
	logic [IW-1:0]                offset;
	logic [IW-1:0]                phys;
	logic                         we;
	logic [bol_pkg::DATA_W-1:0]   wdata;
	logic [bol_pkg::DATA_W-1:0]   rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign full      = (count_q == FULL_CNT);
	assign last_idx  = count_q - CW'(1);
	assign at_last   = (CW'(idx_q) == last_idx);
	assign next_last = ((CW'(idx_q) + CW'(1)) == last_idx);
	assign hit       = (rdata == value_q);

	// offset of DEPTH-1 from head is the slot just before the front
	always_comb begin
		case (state_q)
			ST_IDLE:     offset = (cmd.kind == bol_pkg::KIND_BACK) ? IW'(count_q) : BACK_ONE;
			ST_SHIFT_RD: offset = idx_q + IW'(1);
			default:     offset = idx_q;
		endcase
	end

	bol_addr #(
		.DEPTH(DEPTH)
	) u_addr (
		.head  (head_q),
		.offset(offset),
		.phys  (phys)
	);

	assign we = (accept && !full &&
		(cmd.kind == bol_pkg::KIND_FRONT || cmd.kind == bol_pkg::KIND_BACK)) ||
		(state_q == ST_SHIFT_WR);
	assign wdata = (state_q == ST_SHIFT_WR) ? rdata : cmd.value;

	bol_ram #(
		.WIDTH(bol_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(phys),
		.wdata(wdata),
		.raddr(phys),
		.rdata(rdata)
	);

	// next result word, registered every cycle and qualified by resp_valid_q
	always_comb begin
		resp_d.status = bol_pkg::STATUS_DONE;
		resp_d.data   = '0;
		resp_d.last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (cmd.kind == bol_pkg::KIND_REMOVE) begin
					resp_d.status = bol_pkg::STATUS_EMPTY;
				end else if (full) begin
					resp_d.status = bol_pkg::STATUS_FULL;
				end
			end
			ST_SRCH_CMP: begin
				if (!hit) begin
					resp_d.status = bol_pkg::STATUS_NOT_FOUND;
				end
			end
			ST_SHOW_OUT: begin
				resp_d.status = bol_pkg::STATUS_SHOWN;
				resp_d.data   = $signed(rdata);
				resp_d.last   = at_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			resp_valid_q <= 1'b0;
		end else begin
			resp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd.kind)
							bol_pkg::KIND_FRONT: begin
								resp_valid_q <= 1'b1;
								if (!full) begin
									head_q  <= phys;
									count_q <= count_q + CW'(1);
								end
							end
							bol_pkg::KIND_BACK: begin
								resp_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							bol_pkg::KIND_REMOVE: begin
								if (count_q == '0) begin
									resp_valid_q <= 1'b1;
								end else begin
									state_q <= ST_SRCH_RD;
								end
							end
							bol_pkg::KIND_SHOW: begin
								if (count_q != '0) begin
									state_q <= ST_SHOW_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					if (hit) begin
						if (at_last) begin
							count_q      <= count_q - CW'(1);
							resp_valid_q <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_SHIFT_RD;
						end
					end else if (at_last) begin
						resp_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_SRCH_RD;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					if (next_last) begin
						count_q      <= count_q - CW'(1);
						resp_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_SHOW_RD: begin
					state_q <= ST_SHOW_OUT;
				end
				ST_SHOW_OUT: begin
					resp_valid_q <= 1'b1;
					state_q      <= at_last ? ST_IDLE : ST_SHOW_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		resp_q <= resp_d;
		if (accept) begin
			value_q <= cmd.value;
			idx_q   <= '0;
		end else if ((state_q == ST_SRCH_CMP && !hit) || state_q == ST_SHIFT_WR ||
			state_q == ST_SHOW_OUT) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_insert_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.kind == bol_pkg::KIND_FRONT || cmd.kind == bol_pkg::KIND_BACK))
		|=> (resp_valid && resp.last && !busy))
		else $error("insert did not reply in the next cycle");

	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		(resp_valid && resp.status != bol_pkg::STATUS_SHOWN) |-> (resp.data == '0))
		else $error("status word carries nonzero data");

	a_show_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == bol_pkg::KIND_SHOW && count_q == '0)
		|=> (!busy && !resp_valid))
		else $error("show of empty list produced a word");
`endif

endmodule

`default_nettype wire

>>> tb/bounded_ordered_list_tb.sv
// self-checking testbench for bounded_ordered_list: a directed table, then random commands
// depends on bol_pkg and bounded_ordered_list; results are checked against a shadow list
`timescale 1ns / 1ps

module bounded_ordered_list_tb;

	localparam int DEPTH = 16;
	localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

	typedef struct packed {
		bol_pkg::kind_t                    kind;
		logic signed [bol_pkg::DATA_W-1:0] value;
		int                                reps;
		bit                                typed;
		bol_pkg::status_t                  exp_status;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	bol_pkg::cmd_t   cmd;
	logic            resp_valid;
	bol_pkg::resp_t  resp;

	logic signed [bol_pkg::DATA_W-1:0] shadow_vals [DEPTH];
	int                                shadow_count;
	bol_pkg::resp_t                    expected_resps [$];
	int                                errors;
	bit                                burst;

	bounded_ordered_list #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.resp_valid(resp_valid),
		.resp      (resp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// shadow copy of the list, updated as each word is accepted
	task automatic list_apply(input bol_pkg::cmd_t c);
		int             i;
		bol_pkg::resp_t r;
		r.status = bol_pkg::STATUS_DONE;
		r.data   = '0;
		r.last   = 1'b1;
		case (c.kind)
			bol_pkg::KIND_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = bol_pkg::STATUS_FULL;
				end else begin
					for (i = shadow_count; i > 0; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[0] = c.value;
					shadow_count++;
				end
				expected_resps.push_back(r);
			end
			bol_pkg::KIND_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = bol_pkg::STATUS_FULL;
				end else begin
					shadow_vals[shadow_count] = c.value;
					shadow_count++;
				end
				expected_resps.push_back(r);
			end
			bol_pkg::KIND_REMOVE: begin
				if (shadow_count == 0) begin
					r.status = bol_pkg::STATUS_EMPTY;
				end else begin
					for (i = 0; i < shadow_count; i++)
						if (shadow_vals[i] == c.value) break;
					if (i == shadow_count) begin
						r.status = bol_pkg::STATUS_NOT_FOUND;
					end else begin
						while (i < shadow_count - 1) begin
							shadow_vals[i] = shadow_vals[i+1];
							i++;
						end
						shadow_count--;
					end
				end
				expected_resps.push_back(r);
			end
			default: begin
				for (i = 0; i < shadow_count; i++) begin
					r.status = bol_pkg::STATUS_SHOWN;
					r.data   = shadow_vals[i];
					r.last   = (i == shadow_count - 1);
					expected_resps.push_back(r);
				end
			end
		endcase
	endtask

	// one command word: an optional idle gap, then hold start until busy is low at an edge
	task automatic send_word(input bol_pkg::cmd_t c, input bit typed,
		input bol_pkg::status_t st);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		list_apply(c);
		// status-only rows carry their result typed in the table
		if (typed)
			expected_resps[expected_resps.size()-1] = '{status: st, data: '0, last: 1'b1};
	endtask

	function automatic stim_row_t make_row(bol_pkg::kind_t k,
		logic signed [bol_pkg::DATA_W-1:0] v, int reps, bit typed, bol_pkg::status_t st);
		stim_row_t row;
		row.kind       = k;
		row.value      = v;
		row.reps       = reps;
		row.typed      = typed;
		row.exp_status = st;
		return row;
	endfunction

	function automatic logic signed [bol_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 7) - 3;
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// result check, one field at a time
	always @(posedge clk) begin : check
		bol_pkg::resp_t want;
		if (resp_valid === 1'b1) begin
			if (expected_resps.size() == 0) begin
				$display("%0t: unexpected result status %0d data %0d last %0d",
					$time, resp.status, resp.data, resp.last);
				errors++;
			end else begin
				want = expected_resps.pop_front();
				if (resp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						resp.status);
					errors++;
				end
				if (resp.data !== want.data) begin
					$display("%0t: data expected %0d got %0d", $time, want.data, resp.data);
					errors++;
				end
				if (resp.last !== want.last) begin
					$display("%0t: last expected %0d got %0d", $time, want.last, resp.last);
					errors++;
				end
			end
		end
	end

	initial begin : main
		stim_row_t     dir_rows [$];
		stim_row_t     row;
		bol_pkg::cmd_t c;
		int            r, phase, n, pick, ins_weight;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '{kind: bol_pkg::KIND_FRONT, value: '0};
		errors       = 0;
		shadow_count = 0;
		burst        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows = '{
			make_row(bol_pkg::KIND_SHOW,   32'sh0,        1, 0, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_REMOVE, 32'sd5,        1, 1, bol_pkg::STATUS_EMPTY),
			make_row(bol_pkg::KIND_FRONT,  32'sh7fffffff, 1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_BACK,   32'sh80000000, 1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_FRONT,  32'sh0,        1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_BACK,   -32'sd1,       1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_SHOW,   -32'sd1,       1, 0, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_REMOVE, 32'sd12345,    1, 1, bol_pkg::STATUS_NOT_FOUND),
			make_row(bol_pkg::KIND_REMOVE, 32'sh80000000, 1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_REMOVE, 32'sh0,        1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_FRONT,  32'sd7,        1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_BACK,   32'sd7,        1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_FRONT,  32'sd9,        1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_REMOVE, 32'sd7,        1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_SHOW,   32'sh55555555, 1, 0, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_BACK,   32'sd100,      DEPTH, 0, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_FRONT,  32'sd1,        1, 1, bol_pkg::STATUS_FULL),
			make_row(bol_pkg::KIND_BACK,   32'sd2,        1, 1, bol_pkg::STATUS_FULL),
			make_row(bol_pkg::KIND_SHOW,   32'sh0,        1, 0, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_REMOVE, 32'sd105,      1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_REMOVE, -32'sd1,       1, 1, bol_pkg::STATUS_DONE),
			make_row(bol_pkg::KIND_SHOW,   32'sh0,        1, 0, bol_pkg::STATUS_DONE)
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			for (r = 0; r < row.reps; r++) begin
				c.kind  = row.kind;
				c.value = row.value + r;
				send_word(c, row.typed, row.exp_status);
			end
		end

		// grow, balanced and shrink phases keep the list moving between empty and full
		for (phase = 0; phase < 3; phase++) begin
			ins_weight = (phase == 0) ? 65 : (phase == 1) ? 45 : 25;
			for (n = 0; n < 58; n++) begin
				if (n % 14 == 0) burst = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				c.value = rand_value();
				if (pick < ins_weight) begin
					c.kind = $urandom_range(0, 1) ? bol_pkg::KIND_BACK : bol_pkg::KIND_FRONT;
				end else if (pick < ins_weight + (100 - ins_weight) * 2 / 3) begin
					c.kind = bol_pkg::KIND_REMOVE;
					// mostly remove something that is stored
					if (shadow_count > 0 && $urandom_range(0, 9) < 7)
						c.value = shadow_vals[$urandom_range(0, shadow_count - 1)];
				end else begin
					c.kind = bol_pkg::KIND_SHOW;
				end
				send_word(c, 1'b0, bol_pkg::STATUS_DONE);
			end
		end
		start <= 1'b0;

		while (expected_resps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
hdl/bol_pkg.sv
hdl/bol_ram.sv
hdl/bol_addr.sv
hdl/bounded_ordered_list.sv
tb/bounded_ordered_list_tb.sv
